@@ rtl/shgate_pkg.sv @@
// shared types and constants for the sync header id stream gate
`timescale 1ns / 1ps
`default_nettype none

package shgate_pkg;

    localparam int WIN_LEN   = 32;
    localparam int CELL_CNT  = WIN_LEN - 1;
    localparam int HDR_ONES  = 8;
    localparam int HDR_ZEROS = 8;
    localparam int ID_BASE   = 24;
    localparam int ID_BYTES  = 8;

    localparam logic [7:0]  BYTE_ONES  = 8'hFF;
    localparam logic [7:0]  BYTE_ZERO  = 8'h00;
    localparam logic [63:0] ID_NONE    = 64'd0;
    localparam logic [3:0]  POS_FIRST  = 4'd0;
    localparam logic [3:0]  POS_AUDIO  = 4'd8;

    typedef enum logic [1:0] {
        KIND_AUDIO = 2'd0,
        KIND_TAG   = 2'd1,
        KIND_CLOSE = 2'd2
    } byte_kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] audio_byte;
    } shgate_in_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [1:0]  byte_kind;
        logic [63:0] session_id;
        logic        last;
    } shgate_out_t;

    typedef struct packed {
        logic        hdr_match;
        logic [63:0] id;
        logic [7:0]  audio;
    } win_info_t;

    typedef struct packed {
        logic        close;
        logic [3:0]  pos;
        logic [63:0] id;
        logic [7:0]  audio;
    } job_t;

endpackage

`default_nettype wire

@@ rtl/sync_header_id_stream_gate.sv @@
// top level of the sync header id stream gate
//
// input channel: s_valid / s_ready with s_payload carrying a data byte and an
// audio byte. result channel: m_valid / m_ready with m_payload carrying the
// emitted byte, its kind, the latched session id and a last flag.
// cfg_wr_en / cfg_wr_data write tag_enable, registered, no read-back.
// both bytes enter a chain of 31 cells that, with the incoming pair, forms
// the 32-byte window; a sync header in the data window latches the id.
// a request with results is queued in the cycle it is accepted and its first
// result is registered in the queue before it shows on m_valid.
// throughput: one request per cycle while each causes one result and the
// receiver is ready; a session opening with tagging enabled gives nine results,
// eight tag bytes then the audio byte. requests causing no result are not queued.
// a two-slot result queue lets one request be taken while results wait, so a
// stalled receiver holds s_ready low only once both slots are full.
// reset (synchronous, active low) clears the window, the id, the session
// flag, tag_enable and the queue.
`timescale 1ns / 1ps
`default_nettype none

module sync_header_id_stream_gate
    import shgate_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire shgate_in_t  s_payload,
    output logic             m_valid,
    input  wire logic        m_ready,
    output shgate_out_t      m_payload,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data
);

    logic        accept;
    win_info_t   info;
    logic [63:0] id_new;
    logic        push;
    job_t        job;

    logic [63:0] current_id_reg, current_id_next;
    logic        session_open_reg, session_open_next;
    logic        tag_enable_reg, tag_enable_next;

    assign accept = s_valid && s_ready;

    shgate_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .shift   (accept),
        .d_in    (s_payload),
        .info    (info)
    );

    assign id_new = info.hdr_match ? info.id : current_id_reg;

    always_comb begin
        current_id_next   = current_id_reg;
        session_open_next = session_open_reg;
        tag_enable_next   = cfg_wr_en ? cfg_wr_data : tag_enable_reg;
        push              = 1'b0;
        job.close         = 1'b0;
        job.pos           = POS_AUDIO;
        job.id            = id_new;
        job.audio         = info.audio;
        if (accept) begin
            current_id_next = id_new;
            if (id_new != ID_NONE) begin
                push              = 1'b1;
                session_open_next = 1'b1;
                if (!session_open_reg && tag_enable_reg) begin
                    job.pos = POS_FIRST;
                end
            end else if (session_open_reg) begin
                push              = 1'b1;
                session_open_next = 1'b0;
                job.close         = 1'b1;
                job.audio         = BYTE_ZERO;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            current_id_reg   <= ID_NONE;
            session_open_reg <= 1'b0;
            tag_enable_reg   <= 1'b0;
        end else begin
            current_id_reg   <= current_id_next;
            session_open_reg <= session_open_next;
            tag_enable_reg   <= tag_enable_next;
        end
    end

    shgate_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .job        (job),
        .can_accept (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_payload  (m_payload)
    );

endmodule

`default_nettype wire

@@ rtl/shgate_cell.sv @@
// one window cell holding a data byte and an audio byte
`timescale 1ns / 1ps
`default_nettype none

module shgate_cell
    import shgate_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       shift,
    input  wire shgate_in_t d_in,
    output shgate_in_t      q
);

    shgate_in_t q_reg;
    shgate_in_t q_next;

    always_comb begin
        q_next = q_reg;
        if (shift) begin
            q_next = d_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg <= '0;
        end else begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

@@ rtl/shgate_window.sv @@
// chain of window cells with sync header detection and id extraction
`timescale 1ns / 1ps
`default_nettype none

module shgate_window
    import shgate_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       shift,
    input  wire shgate_in_t d_in,
    output win_info_t       info
);

    // view of the window as it stands once the incoming pair is shifted in
    shgate_in_t view [WIN_LEN];
    shgate_in_t cell_q [CELL_CNT];

    genvar g;
    generate
        for (g = 0; g < CELL_CNT; g++) begin : g_cell
            shgate_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .shift   (shift),
                .d_in    (view[g + 1]),
                .q       (cell_q[g])
            );
            assign view[g] = cell_q[g];
        end
    endgenerate

    assign view[WIN_LEN - 1] = d_in;

    always_comb begin
        logic match;
        logic [63:0] id;
        match = 1'b1;
        id    = ID_NONE;
        for (int k = 0; k < HDR_ONES; k++) begin
            match = match & (view[k].data_byte == BYTE_ONES);
        end
        for (int k = 0; k < HDR_ZEROS; k++) begin
            match = match & (view[HDR_ONES + k].data_byte == BYTE_ZERO);
        end
        for (int k = 0; k < ID_BYTES; k++) begin
            id[8 * k +: 8] = view[ID_BASE + k].data_byte;
        end
        info.hdr_match = match;
        info.id        = id;
        info.audio     = view[0].audio_byte;
    end

endmodule

`default_nettype wire

@@ rtl/shgate_emit.sv @@
// two-slot result queue that expands a request into tag, audio or close results
`timescale 1ns / 1ps
`default_nettype none

module shgate_emit
    import shgate_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire job_t  job,
    output logic       can_accept,
    output logic       m_valid,
    input  wire logic  m_ready,
    output shgate_out_t m_payload
);

    job_t slot0_reg, slot0_next;
    job_t slot1_reg, slot1_next;
    logic slot0_valid_reg, slot0_valid_next;
    logic slot1_valid_reg, slot1_valid_next;

    logic last0;
    logic fin;
    logic adv;

    assign last0 = slot0_reg.close || (slot0_reg.pos == POS_AUDIO);
    assign fin   = slot0_valid_reg && m_ready && last0;
    assign adv   = slot0_valid_reg && m_ready && !last0;

    always_comb begin
        slot0_next       = slot0_reg;
        slot1_next       = slot1_reg;
        slot0_valid_next = slot0_valid_reg;
        slot1_valid_next = slot1_valid_reg;
        if (adv) begin
            slot0_next.pos = slot0_reg.pos + 4'd1;
        end
        if (push) begin
            if (!slot0_valid_reg || fin) begin
                slot0_next       = job;
                slot0_valid_next = 1'b1;
            end else begin
                slot1_next       = job;
                slot1_valid_next = 1'b1;
            end
        end else if (fin) begin
            if (slot1_valid_reg) begin
                slot0_next       = slot1_reg;
                slot1_valid_next = 1'b0;
            end else begin
                slot0_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot0_valid_reg <= 1'b0;
            slot1_valid_reg <= 1'b0;
        end else begin
            slot0_valid_reg <= slot0_valid_next;
            slot1_valid_reg <= slot1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    always_comb begin
        m_payload.session_id = slot0_reg.id;
        m_payload.last       = last0;
        if (slot0_reg.close) begin
            m_payload.out_byte  = BYTE_ZERO;
            m_payload.byte_kind = KIND_CLOSE;
        end else if (slot0_reg.pos[3]) begin
            m_payload.out_byte  = slot0_reg.audio;
            m_payload.byte_kind = KIND_AUDIO;
        end else begin
            m_payload.out_byte  = slot0_reg.id[8 * slot0_reg.pos[2:0] +: 8];
            m_payload.byte_kind = KIND_TAG;
        end
    end

    assign m_valid    = slot0_valid_reg;
    assign can_accept = !slot1_valid_reg;

endmodule

`default_nettype wire

@@ rtl/shgate_checker.sv @@
// port-level assertions for the sync header id stream gate, bound to the top
`timescale 1ns / 1ps
`default_nettype none

module shgate_checker
    import shgate_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire shgate_out_t m_payload
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result changed while stalled");

    // close marker is a lone zero result with no id
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_payload.byte_kind == KIND_CLOSE) |->
            (m_payload.session_id == ID_NONE) && (m_payload.out_byte == BYTE_ZERO)
            && m_payload.last)
        else $error("malformed close marker");

    // tag bytes are always followed by the audio byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && (m_payload.byte_kind == KIND_TAG) |=>
            m_valid && !m_payload.last == (m_payload.byte_kind == KIND_TAG))
        else $error("tag burst ended early");

    // audio only flows inside a session
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_payload.byte_kind == KIND_AUDIO) |->
            (m_payload.session_id != ID_NONE) && m_payload.last)
        else $error("audio result outside a session");

    // reset empties the result queue
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result pending after reset");

endmodule

bind sync_header_id_stream_gate shgate_checker u_checker (.*);

`default_nettype wire
